// ===== sv/value_noise_2d_cosine_top_macros.svh =====
// Assertion helpers used by the value noise back end (vn2c_back).
`ifndef VALUE_NOISE_2D_COSINE_TOP_MACROS_SVH
`define VALUE_NOISE_2D_COSINE_TOP_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define VN2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define VN2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vn2c_pkg.sv =====
// ----------------------------------------------------------------------------
// vn2c_pkg
// Constants, types and the blend function of the value noise datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vn2c_pkg;

  localparam int unsigned ZOOM_W = 24;
  localparam int unsigned FRAC_W = 16;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 24'd65536;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam int unsigned HASH_SHIFT = 13;
  localparam logic [31:0] HASH_K1 = 32'd60493;
  localparam logic [31:0] HASH_K2 = 32'd19990303;
  localparam logic [31:0] HASH_K3 = 32'd1376312589;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned COS_DENS [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef logic signed [31:0] corner_t;
  typedef logic [30:0] weight_t;

  // Linear blend a + floor((b - a) * w / 2^30).
  function automatic corner_t blend(corner_t a, corner_t b, weight_t w);
    logic signed [32:0] diff;
    logic signed [64:0] prod;
    logic signed [64:0] q;
    diff = {b[31], b} - {a[31], a};
    prod = 65'(diff) * 65'($signed({34'd0, w}));
    q = prod >>> 30;
    return corner_t'(a + q[31:0]);
  endfunction

endpackage

`default_nettype wire

// ===== sv/vn2c_fifo.sv =====
// ----------------------------------------------------------------------------
// vn2c_fifo
// Small register queue with the head word visible while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2c_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_i,
  input  wire logic [WIDTH-1:0]             wdata_i,
  input  wire logic                         rd_i,
  output logic      [WIDTH-1:0]             rdata_o,
  output logic                              empty_o,
  output logic                              full_o,
  output logic      [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_wr, do_rd;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;

  always_comb begin
    wr_ptr_d = do_wr ? AW'(wr_ptr_q + AW'(1)) : wr_ptr_q;
    rd_ptr_d = do_rd ? AW'(rd_ptr_q + AW'(1)) : rd_ptr_q;
    count_d  = CW'(count_q + CW'(do_wr) - CW'(do_rd));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vn2c_front.sv =====
// ----------------------------------------------------------------------------
// vn2c_front
// Holds the zoom register and scales each accepted pixel into lattice space.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2c_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  input  wire logic [vn2c_pkg::ZOOM_W-1:0]            cfg_data_i,
  input  wire logic                                   push_i,
  input  wire logic [COORD_BITS-1:0]                  pixel_x_i,
  input  wire logic [COORD_BITS-1:0]                  pixel_y_i,
  input  wire logic                                   q_full_i,
  output logic                                        q_wr_o,
  output logic [2*(COORD_BITS+vn2c_pkg::ZOOM_W)-1:0]  q_data_o
);

  import vn2c_pkg::*;

  localparam int unsigned SW = COORD_BITS + ZOOM_W;

  logic [ZOOM_W-1:0] inv_zoom_q;
  logic [SW-1:0]     sx, sy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_zoom_q <= ZOOM_RESET;
    end else if (cfg_valid_i) begin
      inv_zoom_q <= cfg_data_i;
    end
  end

  assign sx       = SW'(pixel_x_i) * SW'(inv_zoom_q);
  assign sy       = SW'(pixel_y_i) * SW'(inv_zoom_q);
  assign q_wr_o   = push_i & ~q_full_i;
  assign q_data_o = {sy, sx};

endmodule

`default_nettype wire

// ===== sv/vn2c_hash.sv =====
// ----------------------------------------------------------------------------
// vn2c_hash
// Four-stage pipeline from a lattice corner to its signed Q.30 value.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2c_hash (
  input  wire logic              clk_i,
  input  wire logic [31:0]       ix_i,
  input  wire logic [31:0]       iy_i,
  output vn2c_pkg::corner_t      corner_o
);

  import vn2c_pkg::*;

  logic [31:0] n0, n1;
  logic [31:0] n_q, n2_q, n3_q;
  logic [31:0] nn_q, t_q;
  logic [31:0] h;
  corner_t     corner_q;

  assign n0 = ix_i + 32'(iy_i * HASH_MUL_Y);
  assign n1 = (n0 << HASH_SHIFT) ^ n0;
  assign h  = 32'(n3_q * t_q) + HASH_K3;

  always_ff @(posedge clk_i) begin
    n_q      <= n1;
    nn_q     <= 32'(n_q * n_q);
    n2_q     <= n_q;
    t_q      <= 32'(nn_q * HASH_K1) + HASH_K2;
    n3_q     <= n2_q;
    corner_q <= corner_t'(32'(Q30_ONE) - {1'b0, h[30:0]});
  end

  assign corner_o = corner_q;

endmodule

`default_nettype wire

// ===== sv/vn2c_back.sv =====
// ----------------------------------------------------------------------------
// vn2c_back
// Six-stage noise pipeline with credit flow into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "value_noise_2d_cosine_top_macros.svh"

module vn2c_back #(
  parameter int unsigned COORD_BITS        = 12,
  parameter int unsigned WEIGHT_TABLE_BITS = 10,
  parameter int unsigned OUT_FRAC_BITS     = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   q_empty_i,
  input  wire logic [2*(COORD_BITS+vn2c_pkg::ZOOM_W)-1:0] q_data_i,
  output logic                                        q_rd_o,
  input  wire logic                                   pop_i,
  output logic                                        empty_o,
  output logic [OUT_FRAC_BITS-1:0]                    level_o
);

  import vn2c_pkg::*;

  localparam int unsigned SW        = COORD_BITS + ZOOM_W;
  localparam int unsigned TAB_N     = 1 << WEIGHT_TABLE_BITS;
  localparam int unsigned PIPE      = 6;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned IW        = $clog2(PIPE+1);
  localparam int unsigned OCW       = $clog2(OUT_DEPTH+1);
  localparam int unsigned CRW       = OCW + 1;

  typedef logic [30:0] wtab_t [TAB_N];

  function automatic wtab_t build_wtab();
    wtab_t tab;
    longint unsigned u, u2, p, t, s, w;
    for (int k = 0; k < TAB_N; k++) begin
      u  = (longint'(k) * HALF_PI_Q30) >> WEIGHT_TABLE_BITS;
      u2 = (u * u) >> 30;
      p  = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
        t = ((u2 * p) >> 30) / COS_DENS[i];
        p = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
      end
      s = (u * p) >> 30;
      w = (s * s) >> 30;
      tab[k] = 31'((w > Q30_ONE) ? Q30_ONE : w);
    end
    return tab;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  logic [SW-1:0]        sx, sy;
  logic [31:0]          ix, iy, ix1, iy1;
  logic                 issue;
  logic [PIPE-1:0]      valid_q;
  logic [IW-1:0]        inflight_q, inflight_d;
  logic [CRW-1:0]       credit;
  logic [OCW-1:0]       out_count;
  logic                 out_full, out_wr;
  weight_t              wx_q [4];
  weight_t              wy_q [5];
  corner_t              c00, c10, c01, c11;
  corner_t              top_q, bot_q, v;
  logic signed [32:0]   vsum;
  logic [32:0]          shifted;
  logic [OUT_FRAC_BITS-1:0] level_q;

  assign sx  = q_data_i[SW-1:0];
  assign sy  = q_data_i[2*SW-1:SW];
  assign ix  = 32'(sx[SW-1:FRAC_W]);
  assign iy  = 32'(sy[SW-1:FRAC_W]);
  assign ix1 = ix + 32'd1;
  assign iy1 = iy + 32'd1;

  assign credit = CRW'(inflight_q) + CRW'(out_count);
  assign issue  = ~q_empty_i & (credit < CRW'(OUT_DEPTH));
  assign q_rd_o = issue;
  assign out_wr = valid_q[PIPE-1];
  assign inflight_d = IW'(inflight_q + IW'(issue) - IW'(out_wr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      inflight_q <= '0;
    end else begin
      valid_q    <= {valid_q[PIPE-2:0], issue};
      inflight_q <= inflight_d;
    end
  end

  vn2c_hash u_hash00 (.clk_i, .ix_i(ix),  .iy_i(iy),  .corner_o(c00));
  vn2c_hash u_hash10 (.clk_i, .ix_i(ix1), .iy_i(iy),  .corner_o(c10));
  vn2c_hash u_hash01 (.clk_i, .ix_i(ix),  .iy_i(iy1), .corner_o(c01));
  vn2c_hash u_hash11 (.clk_i, .ix_i(ix1), .iy_i(iy1), .corner_o(c11));

  assign v       = blend(top_q, bot_q, wy_q[4]);
  assign vsum    = 33'(v) + 33'sd1073741824;
  assign shifted = 33'(vsum) >> (31 - OUT_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    wx_q[0] <= WTAB[sx[FRAC_W-1 -: WEIGHT_TABLE_BITS]];
    wy_q[0] <= WTAB[sy[FRAC_W-1 -: WEIGHT_TABLE_BITS]];
    for (int i = 1; i < 4; i++) begin
      wx_q[i] <= wx_q[i-1];
    end
    for (int i = 1; i < 5; i++) begin
      wy_q[i] <= wy_q[i-1];
    end
    top_q <= blend(c00, c10, wx_q[3]);
    bot_q <= blend(c01, c11, wx_q[3]);
    if (vsum < 0) begin
      level_q <= '0;
    end else if (shifted > 33'((64'd1 << OUT_FRAC_BITS) - 64'd1)) begin
      level_q <= '1;
    end else begin
      level_q <= shifted[OUT_FRAC_BITS-1:0];
    end
  end

  vn2c_fifo #(
    .WIDTH (OUT_FRAC_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i,
    .rst_ni,
    .wr_i    (out_wr),
    .wdata_i (level_q),
    .rd_i    (pop_i),
    .rdata_o (level_o),
    .empty_o (empty_o),
    .full_o  (out_full),
    .count_o (out_count)
  );

  `VN2C_ASSERT(a_out_no_overflow, !(out_wr && out_full), "result queue written while full")
  `VN2C_ASSERT(a_credit_bound, credit <= CRW'(OUT_DEPTH), "credit exceeds result queue depth")
  `VN2C_ASSERT(a_inflight_match, $countones(valid_q) == 32'(inflight_q), "in-flight count drift")
  `VN2C_ASSERT_NEXT(a_issue_enters, issue, valid_q[0], "issued item missing from pipeline")

endmodule

`default_nettype wire

// ===== sv/value_noise_2d_cosine_top.sv =====
// ----------------------------------------------------------------------------
// value_noise_2d_cosine_top
// 2-D value noise with cosine interpolation, one pixel in and one level out.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     push / full               pixel_x_i, pixel_y_i
// result    pop / empty               cloud_level_o
// config    cfg_valid_i / cfg_ready_o cfg_data_i (inv_zoom)
//
// One pixel is accepted per cycle while full is low; each result comes from
// the six-stage hash and blend pipeline behind a queue.
// The config port is always ready and takes effect on the next accepted pixel.
// Reset clears all queues and loads inv_zoom with 1.0.
// A stalled result side fills the result queue and then the input queue.
// ----------------------------------------------------------------------------
`default_nettype none

module value_noise_2d_cosine_top #(
  parameter int unsigned COORD_BITS        = 12,
  parameter int unsigned WEIGHT_TABLE_BITS = 10,
  parameter int unsigned OUT_FRAC_BITS     = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vn2c_pkg::ZOOM_W-1:0]   cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [COORD_BITS-1:0]         pixel_x_i,
  input  wire logic [COORD_BITS-1:0]         pixel_y_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [OUT_FRAC_BITS-1:0]           cloud_level_o
);

  import vn2c_pkg::*;

  localparam int unsigned QW = 2 * (COORD_BITS + ZOOM_W);

  logic          q_wr, q_rd, q_empty, q_full;
  logic [QW-1:0] q_wdata, q_rdata;
  logic [2:0]    q_count;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  vn2c_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .push_i    (push),
    .pixel_x_i,
    .pixel_y_i,
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_data_o  (q_wdata)
  );

  vn2c_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_mid_q (
    .clk_i,
    .rst_ni,
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  vn2c_back #(
    .COORD_BITS        (COORD_BITS),
    .WEIGHT_TABLE_BITS (WEIGHT_TABLE_BITS),
    .OUT_FRAC_BITS     (OUT_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty | (q_count == 3'd0)),
    .q_data_i  (q_rdata),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .level_o   (cloud_level_o)
  );

endmodule

`default_nettype wire
